>>> hw/rtl/deq_pkg.sv
// Package for the double-ended queue unit: sizes, operation and status codes,
// and the control word that drives the row of storage cells.
// No dependencies.
package deq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int OP_W       = 3;
	localparam int ST_W       = 3;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_PEEK_BACK  = 3'd4,
		OP_PEEK_FRONT = 3'd5,
		OP_READ_INDEX = 3'd6
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL  = 3'd2,
		ST_NULL  = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	typedef struct packed {
		logic                  push_back;
		logic                  push_front;
		logic                  pop_front;
		logic [DATA_WIDTH-1:0] word;
	} deq_ctl_t;

endpackage

>>> hw/rtl/deq_cell.sv
// One storage cell of the deque row: holds a word, loads from the new word,
// from its front-side or back-side neighbor. Depends on deq_pkg.
module deq_cell (
	input  logic                           clk,
	input  deq_pkg::deq_ctl_t              ctl,
	input  logic                           sel,
	input  logic [deq_pkg::DATA_WIDTH-1:0] prev_data,
	input  logic [deq_pkg::DATA_WIDTH-1:0] next_data,
	output logic [deq_pkg::DATA_WIDTH-1:0] data
);
	import deq_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		priority if (ctl.push_front) begin
			data_q <= prev_data;
		end else if (ctl.pop_front) begin
			data_q <= next_data;
		end else if (ctl.push_back && sel) begin
			data_q <= ctl.word;
		end else begin
			data_q <= data_q;
		end
	end

	assign data = data_q;

endmodule

>>> hw/rtl/deq_chain.sv
// Row of DEPTH storage cells, front entry in cell zero; words shift one cell
// per push or pop at the front. Depends on deq_pkg and deq_cell.
module deq_chain (
	input  logic                           clk,
	input  deq_pkg::deq_ctl_t              ctl,
	input  logic [deq_pkg::CNT_W-1:0]      count,
	output logic [deq_pkg::DATA_WIDTH-1:0] cell_data [deq_pkg::DEPTH]
);
	import deq_pkg::*;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [DATA_WIDTH-1:0] prev_w;
			logic [DATA_WIDTH-1:0] next_w;
			logic                  sel_w;

			if (i == 0) begin : g_first
				assign prev_w = ctl.word;
			end else begin : g_mid
				assign prev_w = cell_data[i-1];
			end
			if (i == DEPTH - 1) begin : g_last
				assign next_w = cell_data[i];
			end else begin : g_inner
				assign next_w = cell_data[i+1];
			end
			assign sel_w = (count == CNT_W'(i));

			deq_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.sel       (sel_w),
				.prev_data (prev_w),
				.next_data (next_w),
				.data      (cell_data[i])
			);
		end
	endgenerate

endmodule

>>> hw/rtl/double_ended_queue_unit.sv
// Double-ended queue unit: control, count, read selection and result register.
// Depends on deq_pkg and deq_chain.
//
// Operation channel: op, value, position with op_valid / op_ready. Result
// channel: read_data, status, occupancy, vacant with res_valid / res_ready.
// Every operation gives exactly one result word. Operations are push back,
// push front, pop back, pop front, peek back, peek front and read by index
// from the front; a zero push word is refused, as is a push when full.
// Words live in a row of cells with the front entry in cell zero: a front
// push or pop shifts the whole row by one cell in the same cycle, a back push
// loads the cell at the current count, and reads select one cell.
// The result is registered at the edge that takes the operation. Throughput
// is one operation per cycle while results are taken, set by the single
// result register; op_ready is high while that register is empty or being
// taken in the same cycle.
// When the receiver stalls, the result holds and op_ready drops until it is
// taken. Reset clears the count and result valid; cell contents are not
// cleared and words of unoccupied cells never reach the result.
module double_ended_queue_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           op_valid,
	output logic                           op_ready,
	input  logic [deq_pkg::OP_W-1:0]       op,
	input  logic [deq_pkg::DATA_WIDTH-1:0] value,
	input  logic [deq_pkg::IDX_W-1:0]      position,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [deq_pkg::DATA_WIDTH-1:0] read_data,
	output logic [deq_pkg::ST_W-1:0]       status,
	output logic [deq_pkg::CNT_W-1:0]      occupancy,
	output logic                           vacant
);
	import deq_pkg::*;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  res_valid_q;
	logic [DATA_WIDTH-1:0] read_data_q;
	status_t               status_q;
	logic [CNT_W-1:0]      occupancy_q;
	logic                  vacant_q;

	logic                  fire;
	logic                  empty_w;
	logic                  full_w;
	logic [IDX_W-1:0]      rd_idx;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [DATA_WIDTH-1:0] data_d;
	status_t               status_d;
	deq_ctl_t              ctl;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	assign op_ready = !res_valid_q || res_ready;
	assign fire     = op_valid && op_ready;
	assign empty_w  = (count_q == '0);
	assign full_w   = (count_q == CNT_W'(DEPTH));
	assign rd_word  = cell_data[rd_idx];

	always_comb begin
		count_d        = count_q;
		status_d       = ST_OK;
		data_d         = '0;
		rd_idx         = '0;
		ctl.push_back  = 1'b0;
		ctl.push_front = 1'b0;
		ctl.pop_front  = 1'b0;
		ctl.word       = value;
		unique case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (value == '0) begin
					status_d = ST_NULL;
				end else if (full_w) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
					if (op == OP_PUSH_BACK) begin
						ctl.push_back = fire;
					end else begin
						ctl.push_front = fire;
					end
				end
			end
			OP_POP_BACK, OP_PEEK_BACK: begin
				rd_idx = IDX_W'(count_q - 1'b1);
				if (empty_w) begin
					status_d = ST_EMPTY;
				end else begin
					data_d = rd_word;
					if (op == OP_POP_BACK) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			OP_POP_FRONT, OP_PEEK_FRONT: begin
				if (empty_w) begin
					status_d = ST_EMPTY;
				end else begin
					data_d = rd_word;
					if (op == OP_POP_FRONT) begin
						count_d       = count_q - 1'b1;
						ctl.pop_front = fire;
					end
				end
			end
			OP_READ_INDEX: begin
				rd_idx = position;
				if (CNT_W'(position) >= count_q) begin
					status_d = ST_RANGE;
				end else begin
					data_d = rd_word;
				end
			end
			default: begin
			end
		endcase
	end

	deq_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.count     (count_q),
		.cell_data (cell_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_d;
			end
			if (op_ready) begin
				res_valid_q <= op_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q <= data_d;
			status_q    <= status_d;
			occupancy_q <= count_d;
			vacant_q    <= (count_d == '0);
		end
	end

	assign res_valid = res_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;
	assign vacant    = vacant_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status_d == ST_FULL |-> count_q == CNT_W'(DEPTH))
		else $error("full reported below depth");

	a_live_word: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status_d == ST_OK && (op == OP_POP_BACK || op == OP_POP_FRONT ||
		op == OP_PEEK_BACK || op == OP_PEEK_FRONT) |-> data_d != '0)
		else $error("null word read from a live entry");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> vacant_q == (occupancy_q == '0))
		else $error("empty flag disagrees with occupancy");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
		count_q == $past(count_q) - 1'b1))
		else $error("count moved by more than one");

endmodule

>>> sim/double_ended_queue_unit_tb.sv
// Testbench for double_ended_queue_unit: a directed table, then random operations,
// each result checked against a table value or a deque predictor kept in the bench.
// Depends on deq_pkg and the unit's RTL.
module double_ended_queue_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam logic [OP_W-1:0] OP_NONE = 3'd7;
	localparam int IDLE_PCT     = 19;
	localparam int RANDOM_ITEMS = 1720;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 80;
	localparam int PAUSE_AT     = 1200;

	typedef struct {
		logic [DATA_WIDTH-1:0] data;
		status_t               st;
		logic [CNT_W-1:0]      fill;
		logic                  empty;
	} deq_result_t;

	typedef struct {
		logic [OP_W-1:0]       code;
		logic [DATA_WIDTH-1:0] word;
		logic [IDX_W-1:0]      pos;
		bit                    fixed;
		deq_result_t           want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  op_valid = 1'b0;
	logic                  op_ready;
	logic [OP_W-1:0]       op = '0;
	logic [DATA_WIDTH-1:0] value = '0;
	logic [IDX_W-1:0]      position = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	logic [DATA_WIDTH-1:0] read_data;
	logic [ST_W-1:0]       status;
	logic [CNT_W-1:0]      occupancy;
	logic                  vacant;

	logic [DATA_WIDTH-1:0] model_slots [DEPTH];
	int                    model_head = 0;
	int                    model_tail = 0;
	int                    model_fill = 0;
	deq_result_t           predicted_results [$];
	plan_row_t             plan [$];
	int                    mismatch_count = 0;
	bit                    steady = 1'b0;

	double_ended_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.value     (value),
		.position  (position),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.read_data (read_data),
		.status    (status),
		.occupancy (occupancy),
		.vacant    (vacant)
	);

	always #1 clk = ~clk;

	function automatic deq_result_t deque_apply(input logic [OP_W-1:0] code,
			input logic [DATA_WIDTH-1:0] word, input logic [IDX_W-1:0] pos);
		deq_result_t r;
		int          last;
		r.data = '0;
		r.st = ST_OK;
		case (code)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (word == '0) begin
					r.st = ST_NULL;
				end else if (model_fill >= DEPTH) begin
					r.st = ST_FULL;
				end else if (code == OP_PUSH_BACK) begin
					model_slots[model_tail] = word;
					model_tail = (model_tail + 1) % DEPTH;
					model_fill++;
				end else begin
					model_head = (model_head + DEPTH - 1) % DEPTH;
					model_slots[model_head] = word;
					model_fill++;
				end
			end
			OP_POP_BACK, OP_PEEK_BACK: begin
				if (model_fill == 0) begin
					r.st = ST_EMPTY;
				end else begin
					last = (model_tail + DEPTH - 1) % DEPTH;
					r.data = model_slots[last];
					if (code == OP_POP_BACK) begin
						model_tail = last;
						model_fill--;
					end
				end
			end
			OP_POP_FRONT, OP_PEEK_FRONT: begin
				if (model_fill == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.data = model_slots[model_head];
					if (code == OP_POP_FRONT) begin
						model_head = (model_head + 1) % DEPTH;
						model_fill--;
					end
				end
			end
			OP_READ_INDEX: begin
				if (int'(pos) >= model_fill)
					r.st = ST_RANGE;
				else
					r.data = model_slots[(model_head + int'(pos)) % DEPTH];
			end
			default: ;
		endcase
		r.fill = model_fill[CNT_W-1:0];
		r.empty = (model_fill == 0);
		return r;
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] code,
			input logic [DATA_WIDTH-1:0] word, input logic [IDX_W-1:0] pos,
			input bit fixed = 1'b0, input logic [DATA_WIDTH-1:0] data = '0,
			input status_t st = ST_OK, input logic [CNT_W-1:0] fill = '0);
		plan_row_t row;
		row.code = code;
		row.word = word;
		row.pos = pos;
		row.fixed = fixed;
		row.want.data = data;
		row.want.st = st;
		row.want.fill = fill;
		row.want.empty = (fill == '0);
		plan.push_back(row);
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
		mismatch_count++;
	endtask

	task automatic offer(input logic [OP_W-1:0] code, input logic [DATA_WIDTH-1:0] word,
			input logic [IDX_W-1:0] pos, input bit fixed, input deq_result_t want);
		deq_result_t predicted;
		op_valid <= 1'b1;
		op <= code;
		value <= word;
		position <= pos;
		do @(posedge clk); while (!op_ready);
		predicted = deque_apply(code, word, pos);
		predicted_results.push_back(fixed ? want : predicted);
	endtask

	task automatic maybe_idle();
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			op_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
	endtask

	// Receive side: check each word, stall at random, hold off once for a long stretch.
	initial begin
		int          taken;
		int          hold_left;
		deq_result_t want;
		taken = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				taken++;
				if (predicted_results.size() == 0) begin
					flag_mismatch("unexpected result", 64'(read_data), '0);
				end else begin
					want = predicted_results.pop_front();
					if (read_data !== want.data)
						flag_mismatch("read_data", 64'(read_data), 64'(want.data));
					if (status !== want.st)
						flag_mismatch("status", 64'(status), 64'(want.st));
					if (occupancy !== want.fill)
						flag_mismatch("occupancy", 64'(occupancy), 64'(want.fill));
					if (vacant !== want.empty)
						flag_mismatch("vacant", 64'(vacant), 64'(want.empty));
				end
				if (taken == HOLD_AFTER)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int                    k;
		int                    r;
		int                    mode;
		logic [OP_W-1:0]       code;
		logic [DATA_WIDTH-1:0] word;
		logic [IDX_W-1:0]      pos;
		deq_result_t           none;
		none.data = '0;
		none.st = ST_OK;
		none.fill = '0;
		none.empty = 1'b0;

		add_row(OP_POP_BACK, '1, '0, 1'b1, '0, ST_EMPTY, '0);
		add_row(OP_POP_FRONT, '0, '1, 1'b1, '0, ST_EMPTY, '0);
		add_row(OP_PEEK_BACK, '1, '1, 1'b1, '0, ST_EMPTY, '0);
		add_row(OP_PEEK_FRONT, '0, '0, 1'b1, '0, ST_EMPTY, '0);
		add_row(OP_READ_INDEX, '0, '1, 1'b1, '0, ST_RANGE, '0);
		add_row(OP_READ_INDEX, '1, '0, 1'b1, '0, ST_RANGE, '0);
		add_row(OP_PUSH_BACK, '0, '0, 1'b1, '0, ST_NULL, '0);
		add_row(OP_PUSH_BACK, '1, '0, 1'b1, '0, ST_OK, CNT_W'(1));
		add_row(OP_PUSH_FRONT, 1, '1, 1'b1, '0, ST_OK, CNT_W'(2));
		for (k = 2; k < DEPTH; k++)
			add_row((k % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom | 1, '0);
		add_row(OP_PUSH_BACK, 32'h5, '0, 1'b1, '0, ST_FULL, CNT_W'(DEPTH));
		add_row(OP_PUSH_FRONT, '0, '0, 1'b1, '0, ST_NULL, CNT_W'(DEPTH));
		add_row(OP_READ_INDEX, '0, '1);
		add_row(OP_READ_INDEX, '0, '0);
		add_row(OP_PEEK_BACK, '0, '0);
		add_row(OP_PEEK_FRONT, '0, '0);
		add_row(OP_NONE, '1, '1, 1'b1, '0, ST_OK, CNT_W'(DEPTH));
		add_row(OP_POP_BACK, '0, '0);
		add_row(OP_POP_FRONT, '0, '0);
		add_row(OP_READ_INDEX, '0, IDX_W'(DEPTH - 2), 1'b1, '0, ST_RANGE,
			CNT_W'(DEPTH - 2));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			maybe_idle();
			offer(plan[i].code, plan[i].word, plan[i].pos, plan[i].fixed, plan[i].want);
		end

		// Alternate fill-heavy, drain-heavy and balanced runs to visit full and empty.
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			steady = (k >= 500 && k < 800);
			maybe_idle();
			mode = (k / 48) % 3;
			r = $urandom_range(99);
			if (r < ((mode == 0) ? 60 : (mode == 1) ? 20 : 35))
				code = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else if (r < ((mode == 1) ? 65 : 72))
				code = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
			else if (r < 82)
				code = $urandom_range(1) ? OP_PEEK_FRONT : OP_PEEK_BACK;
			else if (r < 97)
				code = OP_READ_INDEX;
			else
				code = OP_NONE;
			word = $urandom;
			if ($urandom_range(15) == 0)
				word = '0;
			else if ($urandom_range(15) == 0)
				word = '1;
			pos = IDX_W'($urandom_range(DEPTH - 1));
			if (code == OP_READ_INDEX && model_fill > 0 && $urandom_range(9) < 7)
				pos = IDX_W'($urandom_range(model_fill - 1));
			offer(code, word, pos, 1'b0, none);
			if (k == PAUSE_AT) begin
				op_valid <= 1'b0;
				@(posedge clk);
				while (predicted_results.size() > 0) @(posedge clk);
			end
		end
		op_valid <= 1'b0;

		while (predicted_results.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && predicted_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#400_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/deq_chain.sv
hw/rtl/double_ended_queue_unit.sv
sim/double_ended_queue_unit_tb.sv
